### rtl/ddq_pkg.sv
`default_nettype none

package ddq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-cycle command shared by every cell of one chain
  typedef struct packed {
    logic shift_in;
    logic shift_out;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/ddq_cell.sv
`default_nettype none

module ddq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  wire                   clk_i,
  input  ddq_pkg::cell_ctrl_t   ctrl_i,
  input  wire  [CNT_W-1:0]      count_i,
  input  wire  [DATA_WIDTH-1:0] new_i,
  input  wire  [DATA_WIDTH-1:0] left_i,
  input  wire  [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);
  import ddq_pkg::*;

  localparam logic [CNT_W-1:0] Idx = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_in) begin
      data_d = left_i;
    end else if (ctrl_i.shift_out) begin
      data_d = right_i;
    end else if (ctrl_i.load && (count_i == Idx)) begin
      data_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### rtl/ddq_chain.sv
`default_nettype none

module ddq_chain #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7
) (
  input  wire                   clk_i,
  input  ddq_pkg::cell_ctrl_t   ctrl_i,
  input  wire  [CNT_W-1:0]      count_i,
  input  wire  [DATA_WIDTH-1:0] data_i,
  output logic [DATA_WIDTH-1:0] head_o
);
  import ddq_pkg::*;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;

    if (g == 0) begin : g_first
      assign left = data_i;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    ddq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .count_i (count_i),
      .new_i   (data_i),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g])
    );
  end

  assign head_o = cell_data[0];

endmodule

`default_nettype wire

### rtl/double_ended_queue_core.sv
// channel   signals                                   direction  transfer
// command   start_i, busy_o, opcode_i, data_in_i      in         start_i high, busy_o low
// result    valid_o, data_out_o, status_o, count_o    out        valid_o high, one cycle
//
// one command per cycle; busy_o stays low
// the result is registered and strobes in the cycle after its command
// two cell rows hold the queue front-first and back-first, so every read is at cell 0
// reset clears the count, result strobe and status; cell contents and result data are not reset
// the receiver cannot stall, results are never held
`default_nettype none

module double_ended_queue_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire  [2:0]            opcode_i,
  input  wire  [DATA_WIDTH-1:0] data_in_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] data_out_o,
  output logic [1:0]            status_o,
  output logic [CNT_W-1:0]      count_o
);
  import ddq_pkg::*;

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] One  = CNT_W'(1);

  logic                  accept;
  logic                  full;
  logic                  empty;
  cell_ctrl_t            front_ctrl;
  cell_ctrl_t            back_ctrl;
  logic [DATA_WIDTH-1:0] front_head;
  logic [DATA_WIDTH-1:0] back_head;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  valid_q, valid_d;
  status_e               status_q, status_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == Full);
  assign empty  = (cnt_q == '0);

  always_comb begin
    front_ctrl = '0;
    back_ctrl  = '0;
    cnt_d      = cnt_q;
    valid_d    = accept;
    status_d   = ST_OK;
    data_d     = '0;
    if (accept) begin
      case (opcode_i)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            back_ctrl.shift_in = 1'b1;
            front_ctrl.load    = 1'b1;
            cnt_d              = cnt_q + One;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            front_ctrl.shift_in = 1'b1;
            back_ctrl.load      = 1'b1;
            cnt_d               = cnt_q + One;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            data_d              = back_head;
            back_ctrl.shift_out = 1'b1;
            cnt_d               = cnt_q - One;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            data_d               = front_head;
            front_ctrl.shift_out = 1'b1;
            cnt_d                = cnt_q - One;
          end
        end
        OP_PEEK_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            data_d = front_head;
          end
        end
        OP_PEEK_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            data_d = back_head;
          end
        end
        default: begin
        end
      endcase
    end
  end

  ddq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i   (clk_i),
    .ctrl_i  (front_ctrl),
    .count_i (cnt_q),
    .data_i  (data_in_i),
    .head_o  (front_head)
  );

  ddq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk_i   (clk_i),
    .ctrl_i  (back_ctrl),
    .count_i (cnt_q),
    .data_i  (data_in_i),
    .head_o  (back_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o    = valid_q;
  assign data_out_o = data_q;
  assign status_o   = status_q;
  assign count_o    = cnt_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("count above depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("missing result strobe");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_FULL) |-> (count_o == Full))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_EMPTY) |-> (count_o == '0))
    else $error("empty status with stored elements");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !empty && (opcode_i == OP_POP_BACK || opcode_i == OP_POP_FRONT))
    |=> (cnt_q == $past(cnt_q) - One))
    else $error("pop did not decrement count");
`endif

endmodule

`default_nettype wire
